### src/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg - ray/triangle intersect shared types
// Beat structs, register indexes, miss codes and datapath widths.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int CW     = 24;          // coordinate width, signed Q12.12
  localparam int FW     = 12;          // fraction bits
  localparam int DW     = CW + 1;      // vertex differences
  localparam int MW     = 2 * DW;      // difference products
  localparam int PW     = MW + 1;      // cross product components
  localparam int LW     = 26;          // low half of a cross component
  localparam int XW     = 80;          // dot products
  localparam int CKW    = 27;          // chunk width for |d| * |a|
  localparam int NCK    = 3;           // chunks
  localparam int AW     = CKW * NCK;   // magnitudes
  localparam int NW     = 108;         // divider remainder
  localparam int QW     = 26;          // quotient bits
  localparam int RW     = 3;           // miss code width
  localparam int CFG_IW = 3;           // register index width

  localparam logic signed [CW-1:0] DIR_Z_RST = CW'(1 << FW);
  localparam logic signed [CW-1:0] CMAX      = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN      = {1'b1, {(CW-1){1'b0}}};

  // cyclic neighbors for cross products
  localparam int CI1 [3] = '{1, 2, 0};
  localparam int CI2 [3] = '{2, 0, 1};

  typedef enum logic [RW-1:0] {
    RSN_HIT      = 3'd0,
    RSN_DEGEN    = 3'd1,
    RSN_PARALLEL = 3'd2,
    RSN_BEHIND   = 3'd3,
    RSN_OUTSIDE  = 3'd4
  } rsn_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ORG_X = 3'd0,
    CFG_ORG_Y = 3'd1,
    CFG_ORG_Z = 3'd2,
    CFG_DIR_X = 3'd3,
    CFG_DIR_Y = 3'd4,
    CFG_DIR_Z = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } in_beat_t;

  typedef struct packed {
    logic                 hit;
    logic [RW-1:0]        miss_reason;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
  } out_beat_t;

  // one divider stage, three lanes sharing the divisor
  typedef struct packed {
    logic [2:0][NW-1:0] rem;
    logic [2:0][QW-1:0] quo;
    logic [NW-1:0]      dsr;
    logic [2:0]         neg;
    rsn_t               rsn;
  } dq_t;

endpackage

### src/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect - streaming ray versus triangle test
// One ray set by registers, one triangle per input beat, one result beat each.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg_*: write origin x/y/z (index 0..2) and direction x/y/z (index 3..5)
//    while the pipe is empty. cfg_ready is always high; other indexes drop.
//  - in_*: one triangle (three Q12.12 vertices) per beat.
//  - out_*: hit flag, miss code and hit point (zero on a miss) per beat.
// Timing: one triangle per cycle sustained while out_stall holds no output
//  beat. The pipe is 8 arithmetic stages (differences, products, cross sums,
//  split dot products, dot sums, classify, magnitude products, dividend)
//  plus a 26-stage restoring divider (one quotient bit per stage) for the
//  rounded hit offset, and the output register.
// Reset (rst_n low, synchronous): pipe empties, origin = 0, direction =
//  (0, 0, 1.0).
// Stall: the whole pipe moves as one; while the output beat is held by
//  out_stall, in_stall is raised and no stage moves, so nothing is lost.
// The inside test uses s = d.(w0 x v)/(n.d), t = d.(u x w0)/(n.d), exact.
// ----------------------------------------------------------------------------
module ray_triangle_intersect
  import rti_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CW-1:0]     cfg_data
);

  localparam int NST = 8 + QW;

  // ray registers
  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] dir_r [3];

  // pipe control
  logic           adv;
  logic [NST-1:0] vld_r;
  logic           out_valid_r;
  out_beat_t      out_data_r;
  out_beat_t      out_data_nxt;

  // stage 1: differences
  logic signed [CW-1:0] in_a [3];
  logic signed [CW-1:0] in_b [3];
  logic signed [CW-1:0] in_c [3];
  logic signed [DW-1:0] u1_nxt [3], v1_nxt [3], w1_nxt [3];
  logic signed [DW-1:0] u1_r [3], v1_r [3], w1_r [3];
  // stage 2: cross product terms (n = u x v, c1 = w0 x v, c2 = u x w0)
  logic signed [MW-1:0] m2_nxt [3][3][2];
  logic signed [MW-1:0] m2_r [3][3][2];
  logic signed [DW-1:0] w2_r [3];
  // stage 3: cross products
  logic signed [PW-1:0] x3_nxt [3][3];
  logic signed [PW-1:0] x3_r [3][3];
  logic signed [DW-1:0] w3_r [3];
  // stage 4: split dot products (a, b, s, t numerators)
  logic signed [LW+DW:0]    pl4_nxt [4][3];
  logic signed [PW-LW+DW-1:0] ph4_nxt [4][3];
  logic signed [LW+DW:0]    pl4_r [4][3];
  logic signed [PW-LW+DW-1:0] ph4_r [4][3];
  logic                     dgn4_nxt, dgn4_r;
  // stage 5: dot sums
  logic signed [XW-1:0] dot5_nxt [4];
  logic signed [XW-1:0] dot5_r [4];
  logic                 dgn5_r;
  // stage 6: classify
  rsn_t          rsn6_nxt, rsn6_r;
  logic [AW-1:0] absa6_nxt, absa6_r;
  logic [AW-1:0] absb6_nxt, absb6_r;
  logic [2:0]    neg6_nxt, neg6_r;
  // stage 7: |d| * |a| partials
  logic [CW+CKW-1:0] pp7_nxt [3][NCK];
  logic [CW+CKW-1:0] pp7_r [3][NCK];
  logic [AW-1:0]     absb7_r;
  logic [2:0]        neg7_r;
  rsn_t              rsn7_r;
  // stage 8 and divider
  dq_t dq_nxt [QW+1];
  dq_t dq_r   [QW+1];

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DIR_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORG_X: org_r[0] <= cfg_data;
        CFG_ORG_Y: org_r[1] <= cfg_data;
        CFG_ORG_Z: org_r[2] <= cfg_data;
        CFG_DIR_X: dir_r[0] <= cfg_data;
        CFG_DIR_Y: dir_r[1] <= cfg_data;
        CFG_DIR_Z: dir_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipe advance: all stages move together unless the output beat is held
  // --------------------------------------------------------------------------
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NST-2:0], in_valid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  // stage 1: u = B - A, v = C - A, w0 = O - A
  always_comb begin
    in_a[0] = in_data.a_x; in_a[1] = in_data.a_y; in_a[2] = in_data.a_z;
    in_b[0] = in_data.b_x; in_b[1] = in_data.b_y; in_b[2] = in_data.b_z;
    in_c[0] = in_data.c_x; in_c[1] = in_data.c_y; in_c[2] = in_data.c_z;
    for (int k = 0; k < 3; k++) begin
      u1_nxt[k] = DW'(in_b[k]) - DW'(in_a[k]);
      v1_nxt[k] = DW'(in_c[k]) - DW'(in_a[k]);
      w1_nxt[k] = DW'(org_r[k]) - DW'(in_a[k]);
    end
  end

  // stage 2: the six products of each cross
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m2_nxt[0][k][0] = u1_r[CI1[k]] * v1_r[CI2[k]];
      m2_nxt[0][k][1] = u1_r[CI2[k]] * v1_r[CI1[k]];
      m2_nxt[1][k][0] = w1_r[CI1[k]] * v1_r[CI2[k]];
      m2_nxt[1][k][1] = w1_r[CI2[k]] * v1_r[CI1[k]];
      m2_nxt[2][k][0] = u1_r[CI1[k]] * w1_r[CI2[k]];
      m2_nxt[2][k][1] = u1_r[CI2[k]] * w1_r[CI1[k]];
    end
  end

  // stage 3: cross components
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        x3_nxt[c][k] = PW'(m2_r[c][k][0]) - PW'(m2_r[c][k][1]);
      end
    end
  end

  // stage 4: dot terms, each 51-bit factor split in two halves
  always_comb begin
    logic signed [PW-1:0] xo;
    logic signed [DW-1:0] yo;
    dgn4_nxt = (x3_r[0][0] == '0) && (x3_r[0][1] == '0) && (x3_r[0][2] == '0);
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        case (j)
          0:       xo = x3_r[0][k];
          1:       xo = x3_r[0][k];
          2:       xo = x3_r[1][k];
          default: xo = x3_r[2][k];
        endcase
        yo = (j == 0) ? w3_r[k] : DW'(dir_r[k]);
        pl4_nxt[j][k] = $signed({1'b0, xo[LW-1:0]}) * yo;
        ph4_nxt[j][k] = $signed(xo[PW-1:LW]) * yo;
      end
    end
  end

  // stage 5: dot sums
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dot5_nxt[j] = '0;
      for (int k = 0; k < 3; k++) begin
        dot5_nxt[j] = dot5_nxt[j] + (XW'(ph4_r[j][k]) <<< LW) + XW'(pl4_r[j][k]);
      end
    end
  end

  // stage 6: miss classification and magnitudes for the hit point
  always_comb begin
    logic signed [XW-1:0] av, bv;
    logic signed [XW:0]   den, sn, tn;
    logic signed [XW+1:0] st;
    logic                 bneg, outside;
    av   = -dot5_r[0];
    bv   = dot5_r[1];
    bneg = bv[XW-1];
    den  = bneg ? -(XW+1)'(bv) : (XW+1)'(bv);
    sn   = bneg ? -(XW+1)'(dot5_r[2]) : (XW+1)'(dot5_r[2]);
    tn   = bneg ? -(XW+1)'(dot5_r[3]) : (XW+1)'(dot5_r[3]);
    st   = (XW+2)'(sn) + (XW+2)'(tn);
    outside = sn[XW] || tn[XW] || (sn > den) || (st > (XW+2)'(den));
    if (dgn5_r)
      rsn6_nxt = RSN_DEGEN;
    else if (bv == '0)
      rsn6_nxt = RSN_PARALLEL;
    else if ((av != '0) && (av[XW-1] != bneg))
      rsn6_nxt = RSN_BEHIND;
    else if (outside)
      rsn6_nxt = RSN_OUTSIDE;
    else
      rsn6_nxt = RSN_HIT;
    absa6_nxt = av[XW-1] ? AW'(unsigned'(-av)) : AW'(unsigned'(av));
    absb6_nxt = AW'(unsigned'(den));
    for (int k = 0; k < 3; k++) begin
      neg6_nxt[k] = dir_r[k][CW-1] ^ av[XW-1] ^ bneg;
    end
  end

  // stage 7: |d_k| times chunks of |a|
  always_comb begin
    logic [CW-1:0] absd;
    for (int k = 0; k < 3; k++) begin
      absd = dir_r[k][CW-1] ? CW'(unsigned'(-dir_r[k])) : CW'(unsigned'(dir_r[k]));
      for (int c = 0; c < NCK; c++) begin
        pp7_nxt[k][c] = absd * absa6_r[c*CKW +: CKW];
      end
    end
  end

  // stage 8: dividend 2|d a| + |b|, divisor 2|b| (rounds half away from zero),
  // then the divider: one quotient bit per stage, MSB first
  always_comb begin
    logic [NW-1:0] mag;
    logic [NW-1:0] sub;
    dq_nxt[0].dsr = NW'(absb7_r) << 1;
    dq_nxt[0].neg = neg7_r;
    dq_nxt[0].rsn = rsn7_r;
    dq_nxt[0].quo = '0;
    for (int k = 0; k < 3; k++) begin
      mag = '0;
      for (int c = 0; c < NCK; c++) begin
        mag = mag + (NW'(pp7_r[k][c]) << (c * CKW));
      end
      dq_nxt[0].rem[k] = (mag << 1) + NW'(absb7_r);
    end
    for (int i = 0; i < QW; i++) begin
      dq_nxt[i+1] = dq_r[i];
      sub = dq_r[i].dsr << (QW - 1 - i);
      for (int k = 0; k < 3; k++) begin
        if (dq_r[i].rem[k] >= sub) begin
          dq_nxt[i+1].rem[k]           = dq_r[i].rem[k] - sub;
          dq_nxt[i+1].quo[k][QW-1-i] = 1'b1;
        end
      end
    end
  end

  // output: sign the offset, add origin, saturate, zero on a miss
  always_comb begin
    logic signed [QW+1:0] sq;
    logic signed [QW+2:0] p;
    logic signed [CW-1:0] pt [3];
    logic                 hit;
    hit = (dq_r[QW].rsn == RSN_HIT);
    for (int k = 0; k < 3; k++) begin
      sq = $signed({2'b00, dq_r[QW].quo[k]});
      if (dq_r[QW].neg[k]) sq = -sq;
      p = (QW+3)'(org_r[k]) + (QW+3)'(sq);
      if (p > (QW+3)'(CMAX))
        pt[k] = CMAX;
      else if (p < (QW+3)'(CMIN))
        pt[k] = CMIN;
      else
        pt[k] = p[CW-1:0];
      if (!hit) pt[k] = '0;
    end
    out_data_nxt.hit         = hit;
    out_data_nxt.miss_reason = dq_r[QW].rsn;
    out_data_nxt.point_x     = pt[0];
    out_data_nxt.point_y     = pt[1];
    out_data_nxt.point_z     = pt[2];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      u1_r     <= u1_nxt;
      v1_r     <= v1_nxt;
      w1_r     <= w1_nxt;
      m2_r     <= m2_nxt;
      w2_r     <= w1_r;
      x3_r     <= x3_nxt;
      w3_r     <= w2_r;
      pl4_r    <= pl4_nxt;
      ph4_r    <= ph4_nxt;
      dgn4_r   <= dgn4_nxt;
      dot5_r   <= dot5_nxt;
      dgn5_r   <= dgn4_r;
      rsn6_r   <= rsn6_nxt;
      absa6_r  <= absa6_nxt;
      absb6_r  <= absb6_nxt;
      neg6_r   <= neg6_nxt;
      pp7_r    <= pp7_nxt;
      absb7_r  <= absb6_r;
      neg7_r   <= neg6_r;
      rsn7_r   <= rsn6_r;
      dq_r     <= dq_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipe moved during output stall");

  a_degen_code: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[4] && dgn5_r |=> rsn6_r == RSN_DEGEN)
    else $error("degenerate triangle lost its miss code");

  a_hit_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[7] && (dq_r[0].rsn == RSN_HIT) |-> dq_r[0].dsr != '0)
    else $error("hit with zero divisor");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.hit |->
      (out_data_r.point_x == '0) && (out_data_r.point_y == '0) &&
      (out_data_r.point_z == '0))
    else $error("miss beat carries a point");

endmodule

### dv/tb_ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersect - ray/triangle intersect testbench
// Sets a ray through the register port, then streams triangles through the
// pipe. Random idle and stall on both channels. Each result beat is checked
// in order against an exact wide-integer predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ray_triangle_intersect;
  import rti_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam logic [CFG_IW-1:0] CFG_UNUSED_6 = 3'd6;  // no register here
  localparam logic [CFG_IW-1:0] CFG_UNUSED_7 = 3'd7;
  localparam int LATENCY     = 35;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ONE         = 1 << FW;

  // --------------------------------------------------------------------------
  // Scoreboard: ray registers, exact predictor, queue of expected beats
  // --------------------------------------------------------------------------
  class rti_scoreboard;
    wide_t      ray_reg [6];
    out_beat_t  pending [$];
    int         errors;

    function new();
      errors = 0;
      reset_ray();
    endfunction

    function void reset_ray();
      foreach (ray_reg[i]) ray_reg[i] = 0;
      ray_reg[CFG_DIR_Z] = ONE;
    endfunction

    function wide_t sx(logic [CW-1:0] v);
      return wide_t'($signed(v));
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CW-1:0] v);
      if (idx < 6) ray_reg[idx] = sx(v);
    endfunction

    function wide_t dot3(input wide_t x [3], input wide_t y [3]);
      return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    // Exact intersection of the current ray with one triangle
    function void note_triangle(in_beat_t t);
      wide_t va [3], u [3], v [3], n [3], o [3], d [3], w0 [3], wp [3];
      wide_t a, b, uu, uv, vv, wu, wv, den, ns, nt, ab, num, mag, q, p;
      wide_t hi, lo;
      rsn_t rsn;
      out_beat_t e;
      logic [CW-1:0] pt [3];
      va = '{sx(t.a_x), sx(t.a_y), sx(t.a_z)};
      u  = '{sx(t.b_x), sx(t.b_y), sx(t.b_z)};
      v  = '{sx(t.c_x), sx(t.c_y), sx(t.c_z)};
      pt = '{default: '0};
      rsn = RSN_HIT;
      for (int k = 0; k < 3; k++) begin
        u[k]  = u[k] - va[k];
        v[k]  = v[k] - va[k];
        o[k]  = ray_reg[k];
        d[k]  = ray_reg[3 + k];
        w0[k] = o[k] - va[k];
      end
      n[0] = u[1] * v[2] - u[2] * v[1];
      n[1] = u[2] * v[0] - u[0] * v[2];
      n[2] = u[0] * v[1] - u[1] * v[0];
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
        rsn = RSN_DEGEN;
      end else begin
        a = -dot3(n, w0);
        b = dot3(n, d);
        if (b == 0) begin
          rsn = RSN_PARALLEL;
        end else if (a != 0 && ((a < 0) != (b < 0))) begin
          rsn = RSN_BEHIND;
        end else begin
          // wp = b * (P - A), the plane hit scaled by b
          for (int k = 0; k < 3; k++) wp[k] = b * w0[k] + a * d[k];
          uu  = dot3(u, u);
          uv  = dot3(u, v);
          vv  = dot3(v, v);
          wu  = dot3(wp, u);
          wv  = dot3(wp, v);
          den = b * (uv * uv - uu * vv);
          ns  = uv * wv - vv * wu;
          nt  = uv * wu - uu * wv;
          if (den < 0) begin
            den = -den;
            ns  = -ns;
            nt  = -nt;
          end
          if (ns < 0 || ns > den || nt < 0 || ns + nt > den) begin
            rsn = RSN_OUTSIDE;
          end else begin
            ab = (b < 0) ? -b : b;
            hi = wide_t'(CMAX);
            lo = wide_t'(CMIN);
            for (int k = 0; k < 3; k++) begin
              num = d[k] * a;
              mag = (num < 0) ? -num : num;
              // offset rounded to nearest, ties away from zero
              q = (2 * mag + ab) / (2 * ab);
              if ((num < 0) != (b < 0)) q = -q;
              p = o[k] + q;
              if (p > hi) p = hi;
              if (p < lo) p = lo;
              pt[k] = p[CW-1:0];
            end
          end
        end
      end
      e.hit         = (rsn == RSN_HIT);
      e.miss_reason = rsn;
      e.point_x     = pt[0];
      e.point_y     = pt[1];
      e.point_z     = pt[2];
      pending.push_back(e);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) begin
        $display("%0t: hit exp %0d got %0d", $time, e.hit, got.hit);
        errors++;
      end
      if (got.miss_reason !== e.miss_reason) begin
        $display("%0t: miss_reason exp %0d got %0d", $time, e.miss_reason, got.miss_reason);
        errors++;
      end
      if (got.point_x !== e.point_x) begin
        $display("%0t: point_x exp %h got %h", $time, e.point_x, got.point_x);
        errors++;
      end
      if (got.point_y !== e.point_y) begin
        $display("%0t: point_y exp %h got %h", $time, e.point_y, got.point_y);
        errors++;
      end
      if (got.point_z !== e.point_z) begin
        $display("%0t: point_z exp %h got %h", $time, e.point_z, got.point_z);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clocking
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_beat_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_beat_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CW-1:0]     cfg_data = '0;

  ray_triangle_intersect i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rti_scoreboard sb = new();
  int send_idle_pct  = 0;   // sender idle chance per cycle, percent
  int recv_stall_pct = 0;   // receiver stall chance per cycle, percent
  int cycles = 0;

  // receiver: random stall, check each accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One triangle beat, with random idle cycles ahead of it. Valid stays up
  // across back-to-back beats; it drops on an idle cycle, while the pipe drains, or at the end.
  task automatic send_triangle(in_beat_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_triangle(t);
  endtask

  // Hold off until the pipe is empty; register writes only happen after it.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // Full ray update, plus a write to a dead index that must be dropped
  task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    drain();
    write_reg(CFG_ORG_X, CW'(ox));
    write_reg(CFG_ORG_Y, CW'(oy));
    write_reg(CFG_ORG_Z, CW'(oz));
    write_reg(CFG_DIR_X, CW'(dx));
    write_reg(CFG_DIR_Y, CW'(dy));
    write_reg(CFG_DIR_Z, CW'(dz));
    write_reg(($urandom_range(1) != 0) ? CFG_UNUSED_6 : CFG_UNUSED_7, CW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic in_beat_t tri_of(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
    in_beat_t t;
    t.a_x = CW'(ax); t.a_y = CW'(ay); t.a_z = CW'(az);
    t.b_x = CW'(bx); t.b_y = CW'(by); t.b_z = CW'(bz);
    t.c_x = CW'(cx); t.c_y = CW'(cy); t.c_z = CW'(cz);
    return t;
  endfunction

  function automatic int clamp_coord(longint v);
    if (v > longint'(CMAX)) return int'(CMAX);
    if (v < longint'(CMIN)) return int'(CMIN);
    return int'(v);
  endfunction

  // Random triangle: mostly vertices scattered around a point on the ray
  // (so hits, edges and near misses are common), else wide noise or small coordinates.
  function automatic in_beat_t rand_triangle();
    in_beat_t t;
    int sel, spread, vtx [9];
    longint ctr [3];
    sel = $urandom_range(99);
    if (sel < 70) begin
      spread = 1 << $urandom_range(14, 2);
      for (int k = 0; k < 3; k++)
        ctr[k] = longint'(sb.ray_reg[k]) +
                 longint'(sb.ray_reg[3 + k]) * $signed($urandom_range(8, 0)) -
                 longint'(sb.ray_reg[3 + k]) * ($urandom_range(3) == 0);
      for (int i = 0; i < 9; i++) begin
        vtx[i] = clamp_coord(ctr[i % 3] + $signed($urandom_range(2 * spread)) - spread);
        // occasional shared coordinate: flat, edge-on and collinear cases
        if ($urandom_range(15) == 0 && i >= 3) vtx[i] = vtx[i - 3];
      end
      t = tri_of(vtx[0], vtx[1], vtx[2], vtx[3], vtx[4], vtx[5], vtx[6], vtx[7], vtx[8]);
    end else if (sel < 85) begin
      t = in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      t = tri_of($signed($urandom_range(255)) - 128, $signed($urandom_range(255)) - 128,
                 $signed($urandom_range(255)) - 128, $signed($urandom_range(255)) - 128,
                 $signed($urandom_range(255)) - 128, $signed($urandom_range(255)) - 128,
                 $signed($urandom_range(255)) - 128, $signed($urandom_range(255)) - 128,
                 $signed($urandom_range(255)) - 128);
    end
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int mx, mn;
    mx = int'(CMAX);
    mn = int'(CMIN);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset ray: origin 0, heading +z
    send_idle_pct  = 36;
    recv_stall_pct = 55;
    send_triangle(tri_of(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, 0, ONE, 5*ONE)); // hit
    send_triangle(tri_of(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));     // degenerate
    send_triangle(tri_of(0, 0, 0, ONE, 0, 2*ONE, 2*ONE, 0, 4*ONE));         // collinear
    send_triangle(tri_of(0, 0, 0, ONE, 0, ONE, 0, 0, 2*ONE));               // parallel
    send_triangle(tri_of(-ONE, -ONE, -5*ONE, ONE, -ONE, -5*ONE, 0, ONE, -5*ONE)); // behind
    send_triangle(tri_of(9*ONE, 9*ONE, 3*ONE, 11*ONE, 9*ONE, 3*ONE, 9*ONE, 11*ONE, 3*ONE));
    send_triangle(tri_of(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0));          // r is zero
    send_triangle(tri_of(0, 0, 2*ONE, ONE, 0, 2*ONE, 0, ONE, 2*ONE));       // on a vertex
    send_triangle(tri_of(-ONE, 0, ONE, ONE, 0, ONE, 0, ONE, 3*ONE));        // on an edge
    send_triangle(tri_of(mx, mx, mx, mn, mn, mn, mx, mn, mx));
    send_triangle(tri_of(mn, mn, mx, mx, mn, mx, mn, mx, mx));              // far plane
    send_triangle(tri_of(mn, mn, mn, mx, mn, mn, mn, mx, mn));              // far behind
    send_triangle(tri_of(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_triangle(tri_of(mn, mx, 1, mx, mn, -1, mn, mn, mx));

    // Zero direction: everything non-degenerate is parallel
    set_ray(ONE, -ONE, 0, 0, 0, 0);
    send_triangle(tri_of(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, 0, ONE, 5*ONE));
    send_triangle(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));

    // Extreme ray: saturated hit points and huge products
    set_ray(mx, mn, mx, mn, mx, mn);
    send_triangle(tri_of(mn, mn, mn, mx, mn, mn, mn, mx, mn));
    send_triangle(tri_of(mn, mx, mn, mx, mx, mx, mx, mn, mn));
    send_triangle(tri_of(0, 0, 0, mx, 0, 0, 0, mx, mx));
    set_ray(mn, mx, mn, 1, -1, mx);
    send_triangle(tri_of(mn, mn, 0, mx, mn, 0, mn, mx, 0));
    send_triangle(tri_of(mx, mx, mx, mn, mn, mx, mx, mn, mx));
    for (int i = 0; i < 4; i++) send_triangle(rand_triangle());

    // Random phases, ray changed between them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_ray(0, 0, -8*ONE, ONE / 3, -ONE / 5, ONE);
        1: set_ray($signed($urandom_range(2*ONE)) - ONE, $signed($urandom_range(2*ONE)) - ONE,
                   $signed($urandom_range(2*ONE)) - ONE, $signed($urandom_range(512)) - 256,
                   $signed($urandom_range(512)) - 256, $signed($urandom_range(512)) - 256);
        2: set_ray(mn, mn, mn, mx, mx, mx);
        3: set_ray(100*ONE, -50*ONE, 7, -3, 1, 2);
        4: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: set_ray(0, 0, 0, 0, 0, ONE);
      endcase
      // idle pattern by thirds of the random run
      if (ph < 2) begin
        send_idle_pct = 36; recv_stall_pct = 55;
      end else if (ph < 4) begin
        send_idle_pct = 55; recv_stall_pct = 36;
      end else begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      for (int i = 0; i < 250; i++) begin
        send_triangle(rand_triangle());
        // sender holds off once per phase until the pipe has emptied
        if (i == 120) begin
          in_valid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/rti_pkg.sv
src/ray_triangle_intersect.sv
dv/tb_ray_triangle_intersect.sv
